FILE: src/lwes_pkg.sv
package lwes_pkg;

    // Fixed field widths
    localparam int LEN_W      = 11;
    localparam int TARGET_W   = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [TARGET_W-1:0] TARGET_RESET = 24'd1;

    // Item queue between the front and the back end
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_FILL_W    = $clog2(QUEUE_DEPTH + 1);

    // What an item asks the back end to do once its weight has been handled
    typedef struct packed {
        logic clear_window;
        logic emit;
    } lwes_marks_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_SHRINK
    } lwes_state_t;

endpackage

FILE: src/lwes_ram.sv
module lwes_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lwes_front.sv
module lwes_front #(
    parameter int WEIGHT_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [WEIGHT_BITS-1:0] weight,
    input  logic                   end_of_path,
    input  logic                   end_of_set,
    output logic                   q_valid,
    input  logic                   q_ready,
    output logic [WEIGHT_BITS-1:0] q_weight,
    output lwes_pkg::lwes_marks_t  q_marks
);

    logic [WEIGHT_BITS-1:0]       weight_reg [lwes_pkg::QUEUE_DEPTH];
    lwes_pkg::lwes_marks_t        marks_reg  [lwes_pkg::QUEUE_DEPTH];
    logic [lwes_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lwes_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lwes_pkg::Q_FILL_W-1:0] fill_reg, fill_next;
    logic                          push;
    logic                          pop;
    lwes_pkg::lwes_marks_t         in_marks;

    // The end of a set also ends the path, so both clear the window.
    assign in_marks.clear_window = end_of_path | end_of_set;
    assign in_marks.emit         = end_of_set;

    assign s_tready = (fill_reg != lwes_pkg::Q_FILL_W'(lwes_pkg::QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign push     = s_tvalid & s_tready;
    assign pop      = q_valid & q_ready;
    assign q_weight = weight_reg[rd_ptr_reg];
    assign q_marks  = marks_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            weight_reg[wr_ptr_reg] <= weight;
            marks_reg[wr_ptr_reg]  <= in_marks;
        end
    end

endmodule

FILE: src/lwes_back.sv
module lwes_back #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lwes_pkg::TARGET_W-1:0]   cfg_wdata,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  logic [WEIGHT_BITS-1:0]          q_weight,
    input  lwes_pkg::lwes_marks_t           q_marks,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lwes_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = ((WEIGHT_BITS > lwes_pkg::TARGET_W) ?
                            WEIGHT_BITS : lwes_pkg::TARGET_W) + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    lwes_pkg::lwes_state_t state_reg, state_next;
    logic [PTR_W-1:0]              head_reg, head_next;
    logic [PTR_W-1:0]              tail_reg, tail_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [CNT_W-1:0]              best_reg, best_next;
    logic                          ovf_reg, ovf_next;
    logic [lwes_pkg::TARGET_W-1:0] target_reg;
    lwes_pkg::lwes_marks_t         marks_reg, marks_next;
    logic                          byp_valid_reg, byp_valid_next;
    logic [WEIGHT_BITS-1:0]        byp_data_reg, byp_data_next;
    logic                          out_valid_reg, out_valid_next;
    logic [lwes_pkg::LEN_W-1:0]    out_len_reg, out_len_next;
    logic                          out_ovf_reg, out_ovf_next;

    logic                   out_free;
    logic                   pop;
    logic                   ram_we;
    logic [WEIGHT_BITS-1:0] ram_rdata;
    logic [WEIGHT_BITS-1:0] tail_data;
    logic [SUM_W-1:0]       target_ext;
    logic [SUM_W-1:0]       sum_add;
    logic [SUM_W-1:0]       sum_sub;
    logic [CNT_W-1:0]       count_add;
    logic [CNT_W-1:0]       count_sub;
    logic                   fin;
    logic                   f_check;
    logic [CNT_W-1:0]       f_count;
    logic [SUM_W-1:0]       f_sum;
    logic                   f_ovf;
    lwes_pkg::lwes_marks_t  f_marks;
    logic [CNT_W-1:0]       f_best;

    // The read port is addressed with the next tail, so the registered read data holds the weight at the current tail.
    lwes_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (q_weight),
        .raddr (tail_next),
        .rdata (ram_rdata)
    );

    // A weight written into an empty window sits at the tail before the read port has seen it.
    assign tail_data  = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign target_ext = SUM_W'(target_reg);
    assign sum_add    = sum_reg + SUM_W'(q_weight);
    assign sum_sub    = sum_reg - SUM_W'(tail_data);
    assign count_add  = count_reg + 1'b1;
    assign count_sub  = count_reg - 1'b1;

    // An ending set is only taken on when its result has somewhere to go.
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == lwes_pkg::ST_IDLE) && q_valid &&
                      (!q_marks.emit || out_free);
    assign q_ready  = pop;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        marks_next     = marks_reg;
        byp_valid_next = 1'b0;
        byp_data_next  = byp_data_reg;
        out_valid_next = out_valid_reg;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;
        ram_we         = 1'b0;
        fin            = 1'b0;
        f_check        = 1'b0;
        f_count        = count_reg;
        f_sum          = sum_reg;
        f_ovf          = ovf_reg;
        f_marks        = marks_reg;
        f_best         = best_reg;

        unique case (state_reg)
            lwes_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    f_marks = q_marks;
                    if (count_reg == CNT_FULL)
                    begin
                        fin   = 1'b1;
                        f_ovf = 1'b1;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        head_next      = ring_next(head_reg);
                        byp_valid_next = (tail_reg == head_reg);
                        byp_data_next  = q_weight;
                        if (sum_add > target_ext)
                        begin
                            state_next = lwes_pkg::ST_SHRINK;
                            count_next = count_add;
                            sum_next   = sum_add;
                            marks_next = q_marks;
                        end
                        else
                        begin
                            fin     = 1'b1;
                            f_check = 1'b1;
                            f_count = count_add;
                            f_sum   = sum_add;
                        end
                    end
                end
            end
            lwes_pkg::ST_SHRINK:
            begin
                // One weight leaves the window per cycle.
                tail_next = ring_next(tail_reg);
                if (sum_sub > target_ext)
                begin
                    count_next = count_sub;
                    sum_next   = sum_sub;
                end
                else
                begin
                    fin        = 1'b1;
                    f_check    = 1'b1;
                    f_count    = count_sub;
                    f_sum      = sum_sub;
                    state_next = lwes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lwes_pkg::ST_IDLE;
            end
        endcase

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (fin)
        begin
            // A weight turned away by a full store leaves the best length alone.
            f_best     = (f_check && (f_sum == target_ext) && (f_count > best_reg)) ?
                         f_count : best_reg;
            count_next = f_count;
            sum_next   = f_sum;
            best_next  = f_best;
            ovf_next   = f_ovf;
            if (f_marks.clear_window)
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
                sum_next   = '0;
            end
            if (f_marks.emit)
            begin
                out_valid_next = 1'b1;
                out_len_next   = lwes_pkg::LEN_W'(f_best);
                out_ovf_next   = f_ovf;
                best_next      = '0;
                ovf_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lwes_pkg::ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            target_reg    <= lwes_pkg::TARGET_RESET;
            marks_reg     <= '0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            marks_reg     <= marks_next;
            byp_valid_reg <= byp_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= byp_data_next;
        out_len_reg  <= out_len_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lwes_pkg::OUT_DATA_W'({out_ovf_reg, out_len_reg});

    a_empty_window_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("empty window holds a non-zero sum");

    a_shrink_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lwes_pkg::ST_SHRINK) |-> (count_reg != '0))
        else $error("shrinking an empty window");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && f_marks.emit) |=> out_valid_reg)
        else $error("end of set did not present a result");

endmodule

FILE: src/longest_window_exact_sum.sv
// A result appears on m_tvalid once the transaction that ends the set has left the item queue
// and the back end has dropped from the window every weight that transaction pushes out.
// Dropping weights holds the back end in its shrink state, as the window store has a single
// read port at the tail; meanwhile the item queue takes new items until it is full.
// Reset clears all pointers, counts, sums and flags and sets target_sum to 1; the window
// store is not cleared and needs no clearing pass, so items are taken straight after reset.
module longest_window_exact_sum #(
    parameter int WINDOW_DEPTH = 1024,
    parameter int WEIGHT_BITS  = 16,
    localparam int IN_DATA_W   = ((WEIGHT_BITS + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_DATA_W-1:0]            s_tdata,   // weight
    input  logic                            s_tlast,   // end_of_path
    input  logic                            s_tuser,   // end_of_set
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lwes_pkg::OUT_DATA_W-1:0] m_tdata,   // best_length, overflow
    input  logic                            cfg_we,
    input  logic [lwes_pkg::TARGET_W-1:0]   cfg_wdata  // target_sum
);

    logic                   q_valid;
    logic                   q_ready;
    logic [WEIGHT_BITS-1:0] q_weight;
    lwes_pkg::lwes_marks_t  q_marks;

    lwes_front #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .weight      (s_tdata[WEIGHT_BITS-1:0]),
        .end_of_path (s_tlast),
        .end_of_set  (s_tuser),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_weight    (q_weight),
        .q_marks     (q_marks)
    );

    lwes_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_weight  (q_weight),
        .q_marks   (q_marks),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: bench/longest_window_exact_sum_tb.sv
module longest_window_exact_sum_tb;

    localparam int WINDOW_DEPTH = 1024;
    localparam int WEIGHT_BITS  = 16;
    localparam int DRAIN_CYCLES = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS     = 26;

    typedef enum logic
    {
        ROW_ITEM,
        ROW_TARGET
    } row_kind_t;

    // One row of the directed table: a transaction or a write of target_sum.
    typedef struct packed {
        row_kind_t                     kind;
        logic [lwes_pkg::TARGET_W-1:0] value;
        logic                          eop;
        logic                          eos;
        logic                          typed;
        logic [lwes_pkg::LEN_W-1:0]    len;
        logic                          ovf;
    } dir_row_t;

    typedef struct packed {
        logic [lwes_pkg::LEN_W-1:0] best_length;
        logic                       overflow;
    } set_result_t;

    // Rows marked typed carry their result; the others go through the predictor.
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{ROW_ITEM,   24'd1,        1'b0, 1'b1, 1'b1, 11'd1, 1'b0},
        '{ROW_ITEM,   24'd65535,    1'b0, 1'b1, 1'b1, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd0,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd0,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd1,        1'b0, 1'b1, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd1,        1'b1, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd2,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd1,        1'b1, 1'b1, 1'b0, 11'd0, 1'b0},
        '{ROW_TARGET, 24'd0,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd0,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd0,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd5,        1'b0, 1'b1, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd7,        1'b0, 1'b1, 1'b1, 11'd0, 1'b0},
        '{ROW_TARGET, 24'hFFFFFF,   1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd65535,    1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd65535,    1'b1, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd65535,    1'b0, 1'b1, 1'b0, 11'd0, 1'b0},
        '{ROW_TARGET, 24'd3,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd1,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd2,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd1,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd2,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd3,        1'b1, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd1,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd1,        1'b0, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_ITEM,   24'd1,        1'b0, 1'b1, 1'b0, 11'd0, 1'b0}
    };

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata   = '0;   // weight
    logic                            s_tlast   = 1'b0; // end_of_path
    logic                            s_tuser   = 1'b0; // end_of_set
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [lwes_pkg::OUT_DATA_W-1:0] m_tdata;          // best_length, overflow
    logic                            cfg_we    = 1'b0;
    logic [lwes_pkg::TARGET_W-1:0]   cfg_wdata = '0;   // target_sum

    // Predictor state
    logic [lwes_pkg::TARGET_W-1:0] model_target = lwes_pkg::TARGET_RESET;
    logic [WEIGHT_BITS-1:0]        window_weights[$];
    longint unsigned               window_total = 0;
    logic [lwes_pkg::LEN_W-1:0]    set_best     = '0;
    logic                          set_overflow = 1'b0;

    set_result_t            pending_results[$];
    set_result_t            seen_result;
    int                     errors        = 0;
    int                     src_idle_pct  = 0;
    int                     snk_stall_pct = 0;
    int                     cycle_count;

    always #5 clk = ~clk;

    longest_window_exact_sum u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Appends one weight unless the window is full (then flags overflow), shrinks from the
    // oldest end, tracks the best exact-sum length; a set mark emits, clears per-set state.
    task automatic advance_window(input logic [WEIGHT_BITS-1:0] w, input logic eop,
                                  input logic eos, output logic emitted,
                                  output set_result_t res);
        emitted = 1'b0;
        res     = '0;
        if (window_weights.size() >= WINDOW_DEPTH)
        begin
            set_overflow = 1'b1;
        end
        else
        begin
            window_weights.insert(window_weights.size(), w);
            window_total += w;
            while (window_total > model_target && window_weights.size() > 0)
                window_total -= window_weights.pop_front();
            if (window_total == model_target && window_weights.size() > set_best)
                set_best = lwes_pkg::LEN_W'(window_weights.size());
        end
        if (eop || eos)
        begin
            window_weights.delete();
            window_total = 0;
        end
        if (eos)
        begin
            res.best_length = set_best;
            res.overflow    = set_overflow;
            emitted         = 1'b1;
            set_best        = '0;
            set_overflow    = 1'b0;
        end
    endtask

    task automatic send_weight(input logic [WEIGHT_BITS-1:0] w, input logic eop,
                               input logic eos, input logic typed,
                               input set_result_t typed_res);
        logic        emitted;
        set_result_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= eop;
        s_tuser  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_window(w, eop, eos, emitted, res);
        if (emitted)
            pending_results.insert(pending_results.size(), typed ? typed_res : res);
    endtask

    // The block may still be dropping weights after its last result, so the write
    // waits out the longest shrink as well.
    task automatic set_target(input logic [lwes_pkg::TARGET_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        model_target = value;
    endtask

    // Sets of one to four paths with random content, plus the odd full-range weight
    // and the odd set mark in the middle of a path.
    task automatic run_sets(input int n_items, input int w_max, input int zero_pct);
        int                     sent;
        int                     paths;
        int                     plen;
        logic [WEIGHT_BITS-1:0] w;
        logic                   eop;
        logic                   eos;
        logic                   last_of_set;
        sent = 0;
        while (sent < n_items)
        begin
            paths = $urandom_range(1, 4);
            for (int p = 0; p < paths; p++)
            begin
                plen = $urandom_range(1, 24);
                for (int k = 0; k < plen; k++)
                begin
                    if ($urandom_range(99) < 6)
                        w = WEIGHT_BITS'($urandom_range(0, 65535));
                    else if ($urandom_range(99) < zero_pct)
                        w = '0;
                    else
                        w = WEIGHT_BITS'($urandom_range(1, w_max));
                    last_of_set = (p == paths - 1) && (k == plen - 1);
                    eos = last_of_set || ($urandom_range(99) < 2);
                    eop = (k == plen - 1) && !(last_of_set && $urandom_range(1) == 0);
                    send_weight(w, eop, eos, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: best_length %0d, overflow %0d",
                       m_tdata[lwes_pkg::LEN_W-1:0], m_tdata[lwes_pkg::LEN_W]);
                errors++;
            end
            else
            begin
                seen_result = pending_results.pop_front();
                if (m_tdata[lwes_pkg::LEN_W-1:0] !== seen_result.best_length)
                begin
                    $error("best_length: expected %0d, got %0d",
                           seen_result.best_length, m_tdata[lwes_pkg::LEN_W-1:0]);
                    errors++;
                end
                if (m_tdata[lwes_pkg::LEN_W] !== seen_result.overflow)
                begin
                    $error("overflow: expected %0d, got %0d",
                           seen_result.overflow, m_tdata[lwes_pkg::LEN_W]);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("longest_window_exact_sum verification failed");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_TARGET)
                set_target(DIRECTED_ROWS[i].value);
            else
                send_weight(DIRECTED_ROWS[i].value[WEIGHT_BITS-1:0], DIRECTED_ROWS[i].eop,
                            DIRECTED_ROWS[i].eos, DIRECTED_ROWS[i].typed,
                            set_result_t'{DIRECTED_ROWS[i].len, DIRECTED_ROWS[i].ovf});
        end

        // Small targets and weights, so exact sums turn up often.
        set_target(lwes_pkg::TARGET_W'($urandom_range(1, 40)));
        run_sets(60, 12, 5);
        set_target(lwes_pkg::TARGET_W'($urandom_range(1, 40)));
        run_sets(60, 12, 5);

        src_idle_pct = 55;
        set_target(lwes_pkg::TARGET_W'($urandom_range(200, 3000)));
        run_sets(60, 300, 3);
        set_target(lwes_pkg::TARGET_W'($urandom_range(200, 3000)));
        run_sets(60, 300, 3);

        src_idle_pct  = 0;
        snk_stall_pct = 55;
        set_target(lwes_pkg::TARGET_W'($urandom_range(1, 16)));
        run_sets(60, 6, 10);
        set_target(24'd0);
        run_sets(60, 6, 30);

        src_idle_pct  = 14;
        snk_stall_pct = 14;
        set_target(lwes_pkg::TARGET_W'($urandom_range(60000, 200000)));
        run_sets(60, 65535, 2);
        set_target(lwes_pkg::TARGET_W'($urandom_range(1, 24'hFFFFFF)));
        run_sets(60, 65535, 2);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("longest_window_exact_sum verification clean");
        else
            $display("longest_window_exact_sum verification failed");
        $finish;
    end

endmodule

FILE: longest_window_exact_sum.f
src/lwes_pkg.sv
src/lwes_ram.sv
src/lwes_front.sv
src/lwes_back.sv
src/longest_window_exact_sum.sv
bench/longest_window_exact_sum_tb.sv
